>>> rtl/vde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vde_pkg
// Shared types and constants of the vector distance engine.
// ----------------------------------------------------------------------------
package vde_pkg;

   localparam int METRIC_W    = 2;
   localparam int DIMS_W      = 9;
   localparam int INDEX_W     = 9;
   localparam int ACC_W       = 40;
   localparam int DIST_W      = 24;
   localparam int ROOT_W      = ACC_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [METRIC_W-1:0] METRIC_EUCLID  = 2'd0;
   localparam logic [METRIC_W-1:0] METRIC_MAX     = 2'd1;
   localparam logic [METRIC_W-1:0] METRIC_TAXICAB = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN_METRIC = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_METRIC  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN_DIMS   = 2'd2;

   localparam logic [INDEX_W-1:0] INDEX_MAX     = '1;
   localparam logic [ACC_W-1:0]   ACC_MAX       = '1;
   localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
   // highest power of four the root search starts from (2^40)
   localparam logic [ROOT_W-1:0]  ROOT_BIT_INIT = 41'h100_0000_0000;

   typedef struct packed {
      logic [METRIC_W-1:0] domain_metric;
      logic [METRIC_W-1:0] range_metric;
      logic [DIMS_W-1:0]   domain_dims;
   } cfg_type;

   typedef struct packed {
      logic to_domain;
      logic use_max;
      logic last;
   } item_ctrl_type;

   typedef struct packed {
      logic root_busy;
      logic emit;
   } back_status_type;

   typedef struct packed {
      logic [ACC_W-1:0]  rem;
      logic [ROOT_W-1:0] res;
   } root_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_ROOT,
      ST_EMIT
   } back_state_type;

endpackage

>>> rtl/vde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vde_front
// Takes coordinate beats, tracks the coordinate index, routes each beat to
// the domain or range part and forms its increment (square or distance).
// ----------------------------------------------------------------------------
module vde_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vde_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_coord_a,
   input  logic signed [COORD_BITS-1:0] req_coord_b,
   input  logic                         req_last_coord,
   input  logic                         q_in_ready,
   output logic                         q_push,
   output logic [2*COORD_BITS-1:0]      q_value,
   output vde_pkg::item_ctrl_type       q_ctrl
);
   import vde_pkg::*;

   localparam int VALUE_W = 2 * COORD_BITS;

   logic [INDEX_W-1:0]    coord_index_ff;
   logic [INDEX_W-1:0]    coord_index_in;
   logic [COORD_BITS:0]   ext_a;
   logic [COORD_BITS:0]   ext_b;
   logic [COORD_BITS:0]   diff;
   logic [COORD_BITS-1:0] abs_d;
   logic [VALUE_W-1:0]    square;
   logic                  is_domain;
   logic [METRIC_W-1:0]   metric;

   assign req_ready = q_in_ready;
   assign q_push    = req_valid && q_in_ready;

   assign ext_a  = {req_coord_a[COORD_BITS-1], req_coord_a};
   assign ext_b  = {req_coord_b[COORD_BITS-1], req_coord_b};
   assign diff   = (req_coord_a >= req_coord_b) ? (ext_a - ext_b) : (ext_b - ext_a);
   assign abs_d  = diff[COORD_BITS-1:0];
   assign square = VALUE_W'(abs_d) * VALUE_W'(abs_d);

   assign is_domain = coord_index_ff < cfg.domain_dims;
   assign metric    = is_domain ? cfg.domain_metric : cfg.range_metric;

   assign q_value          = (metric == METRIC_EUCLID) ? square : VALUE_W'(abs_d);
   assign q_ctrl.to_domain = is_domain;
   assign q_ctrl.use_max   = (metric == METRIC_MAX);
   assign q_ctrl.last      = req_last_coord;

   always_comb begin
      coord_index_in = coord_index_ff;
      if (q_push) begin
         if (req_last_coord) begin
            coord_index_in = '0;
         end else if (coord_index_ff != INDEX_MAX) begin
            coord_index_in = coord_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_index_ff <= '0;
      end else begin
         coord_index_ff <= coord_index_in;
      end
   end

endmodule

>>> rtl/vde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vde_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module vde_queue #(
   parameter int WIDTH = 35
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_pop,
   output logic [WIDTH-1:0] out_data
);
   import vde_pkg::*;

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = in_push && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/vde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vde_back
// Accumulates queued increments per part, runs the square roots at the end
// of a vector and holds the result in the output register.
// ----------------------------------------------------------------------------
module vde_back #(
   parameter int VALUE_W = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vde_pkg::cfg_type               cfg,
   input  logic                           q_valid,
   input  logic [VALUE_W-1:0]             q_value,
   input  vde_pkg::item_ctrl_type         q_ctrl,
   output logic                           q_pop,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [vde_pkg::DIST_W-1:0]     rsp_distance,
   output vde_pkg::back_status_type       status
);
   import vde_pkg::*;

   localparam int SUM_W = ((VALUE_W > ACC_W) ? VALUE_W : ACC_W) + 1;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [ACC_W-1:0]  dom_acc_ff;
   logic [ACC_W-1:0]  dom_acc_in;
   logic [ACC_W-1:0]  rng_acc_ff;
   logic [ACC_W-1:0]  rng_acc_in;
   root_type          root_dom_ff;
   root_type          root_dom_in;
   root_type          root_rng_ff;
   root_type          root_rng_in;
   logic [ROOT_W-1:0] root_bit_ff;
   logic [ROOT_W-1:0] root_bit_in;
   logic [DIST_W-1:0] fin_dom_ff;
   logic [DIST_W-1:0] fin_dom_in;
   logic [DIST_W-1:0] fin_rng_ff;
   logic [DIST_W-1:0] fin_rng_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DIST_W-1:0] rsp_distance_ff;
   logic [DIST_W-1:0] rsp_distance_in;

   logic [ACC_W-1:0]  acc_sel;
   logic [SUM_W-1:0]  acc_ext;
   logic [SUM_W-1:0]  val_ext;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  larger;
   logic [SUM_W-1:0]  cand;
   logic [ACC_W-1:0]  acc_new;
   logic [DIST_W-1:0] dom_dist;
   logic [DIST_W-1:0] rng_dist;

   // one result bit per call of the digit-by-digit square root
   function automatic root_type root_step(input root_type cur,
                                          input logic [ROOT_W-1:0] bit_v);
      root_type          nxt;
      logic [ROOT_W-1:0] trial;
      trial = cur.res + bit_v;
      if (ROOT_W'(cur.rem) >= trial) begin
         nxt.rem = cur.rem - trial[ACC_W-1:0];
         nxt.res = (cur.res >> 1) + bit_v;
      end else begin
         nxt.rem = cur.rem;
         nxt.res = cur.res >> 1;
      end
      return nxt;
   endfunction

   function automatic logic [DIST_W-1:0] sat_dist(input logic [ACC_W-1:0] acc);
      return (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
   endfunction

   assign acc_sel = q_ctrl.to_domain ? dom_acc_ff : rng_acc_ff;
   assign acc_ext = SUM_W'(acc_sel);
   assign val_ext = SUM_W'(q_value);
   assign sum     = acc_ext + val_ext;
   assign larger  = (val_ext > acc_ext) ? val_ext : acc_ext;
   assign cand    = q_ctrl.use_max ? larger : sum;
   assign acc_new = (cand > SUM_W'(ACC_MAX)) ? ACC_MAX : cand[ACC_W-1:0];

   assign dom_dist = (cfg.domain_metric == METRIC_EUCLID) ?
                     root_dom_ff.res[DIST_W-1:0] : fin_dom_ff;
   assign rng_dist = (cfg.range_metric == METRIC_EUCLID) ?
                     root_rng_ff.res[DIST_W-1:0] : fin_rng_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   always_comb begin
      state_in         = state_ff;
      dom_acc_in       = dom_acc_ff;
      rng_acc_in       = rng_acc_ff;
      root_dom_in      = root_dom_ff;
      root_rng_in      = root_rng_ff;
      root_bit_in      = root_bit_ff;
      fin_dom_in       = fin_dom_ff;
      fin_rng_in       = fin_rng_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_distance_in  = rsp_distance_ff;
      q_pop            = 1'b0;
      status.root_busy = 1'b0;
      status.emit      = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            q_pop = q_valid;
            if (q_valid) begin
               if (q_ctrl.to_domain) begin
                  dom_acc_in = acc_new;
               end else begin
                  rng_acc_in = acc_new;
               end
               if (q_ctrl.last) begin
                  // snapshot both parts, clear for the next vector
                  root_dom_in.rem = dom_acc_in;
                  root_dom_in.res = '0;
                  root_rng_in.rem = rng_acc_in;
                  root_rng_in.res = '0;
                  fin_dom_in      = sat_dist(dom_acc_in);
                  fin_rng_in      = sat_dist(rng_acc_in);
                  root_bit_in     = ROOT_BIT_INIT;
                  dom_acc_in      = '0;
                  rng_acc_in      = '0;
                  state_in        = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            status.root_busy = 1'b1;
            root_dom_in      = root_step(root_dom_ff, root_bit_ff);
            root_rng_in      = root_step(root_rng_ff, root_bit_ff);
            root_bit_in      = root_bit_ff >> 2;
            if (root_bit_ff == ROOT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               status.emit     = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_distance_in = (dom_dist > rng_dist) ? dom_dist : rng_dist;
               state_in        = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         dom_acc_ff   <= '0;
         rng_acc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dom_acc_ff   <= dom_acc_in;
         rng_acc_ff   <= rng_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_dom_ff     <= root_dom_in;
      root_rng_ff     <= root_rng_in;
      root_bit_ff     <= root_bit_in;
      fin_dom_ff      <= fin_dom_in;
      fin_rng_ff      <= fin_rng_in;
      rsp_distance_ff <= rsp_distance_in;
   end

endmodule

>>> rtl/vector_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_engine
// Distance between two integer vectors streamed one coordinate pair per beat,
// with separate Euclidean, maximum or taxicab metrics for the domain and
// range parts.
// ----------------------------------------------------------------------------
// Coordinate beats are taken one per cycle while the queue has room and
// accumulated one per cycle while the back part is accumulating.
// The beat marked last_coord ends the vector: the back part then runs the
// digit-by-digit square roots of both parts side by side, one result bit per
// cycle, and then loads the output register. During the root the two-entry
// queue still takes up to two beats of the next vector, and a finished
// distance waits in the output register without holding up the next
// vector's coordinates.
module vector_distance_engine #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_BITS-1:0]        req_coord_a,
   input  logic signed [COORD_BITS-1:0]        req_coord_b,
   input  logic                                req_last_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vde_pkg::DIST_W-1:0]          rsp_distance,
   input  logic                                csr_write_en,
   input  logic [vde_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vde_pkg::CSR_DATA_W-1:0]      csr_data
);
   import vde_pkg::*;

   localparam int VALUE_W = 2 * COORD_BITS;
   localparam int CTRL_W  = $bits(item_ctrl_type);
   localparam int ENTRY_W = VALUE_W + CTRL_W;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic               q_in_ready;
   logic               q_push;
   logic [VALUE_W-1:0] q_in_value;
   item_ctrl_type      q_in_ctrl;
   logic               q_out_valid;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_out_data;
   logic [VALUE_W-1:0] q_out_value;
   item_ctrl_type      q_out_ctrl;
   back_status_type    back_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DOMAIN_METRIC: cfg_in.domain_metric = csr_data[METRIC_W-1:0];
            CSR_RANGE_METRIC:  cfg_in.range_metric  = csr_data[METRIC_W-1:0];
            CSR_DOMAIN_DIMS:   cfg_in.domain_dims   = csr_data[DIMS_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vde_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coord_a    (req_coord_a),
      .req_coord_b    (req_coord_b),
      .req_last_coord (req_last_coord),
      .q_in_ready     (q_in_ready),
      .q_push         (q_push),
      .q_value        (q_in_value),
      .q_ctrl         (q_in_ctrl)
   );

   vde_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (q_push),
      .in_ready  (q_in_ready),
      .in_data   ({q_in_ctrl, q_in_value}),
      .out_valid (q_out_valid),
      .out_pop   (q_pop),
      .out_data  (q_out_data)
   );

   assign q_out_value = q_out_data[VALUE_W-1:0];
   assign q_out_ctrl  = q_out_data[ENTRY_W-1 -: CTRL_W];

   vde_back #(
      .VALUE_W (VALUE_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_out_valid),
      .q_value      (q_out_value),
      .q_ctrl       (q_out_ctrl),
      .q_pop        (q_pop),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_distance (rsp_distance),
      .status       (back_status)
   );

`ifndef ASSERT_OFF
   // a result beat only appears after the back part finished a vector
   a_rsp_after_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_status.emit))
      else $error("result beat without a finished vector");

   // no queue entry is consumed while the roots are running or the queue is empty
   a_pop_legal: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_out_valid && !back_status.root_busy))
      else $error("queue popped while empty or during root");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

>>> sim/vector_distance_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_engine_test
// Streams coordinate beats with random bursts and gaps into the distance
// engine under a series of metric and domain-size settings, predicts every
// vector distance in a scoreboard and checks each result beat against it
// while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module vector_distance_engine_test;

   import vde_pkg::*;

   typedef longint unsigned wide_type;
   typedef logic signed [15:0] coord_type;

   localparam int       CYCLE_LIMIT = 400000;
   localparam int       SETTLE      = 40;
   localparam wide_type ACC_LIMIT   = ACC_MAX;
   localparam wide_type DIST_LIMIT  = DIST_MAX;
   // unnamed fourth metric code, the engine treats it as taxicab
   localparam logic [METRIC_W-1:0] METRIC_SPARE = 2'd3;

   // vector content styles
   localparam int FILL_RANDOM = 0;
   localparam int FILL_EXTREME = 1;
   localparam int FILL_CLOSE = 2;
   localparam int FILL_SPREAD = 3;

   class distance_scoreboard;
      logic [METRIC_W-1:0] domain_metric;
      logic [METRIC_W-1:0] range_metric;
      logic [DIMS_W-1:0]   domain_dims;
      wide_type            domain_sum;
      wide_type            range_sum;
      logic [INDEX_W-1:0]  coord_pos;
      logic [DIST_W-1:0]   expected_distances[$];
      int                  errors;

      function new();
         domain_metric = METRIC_EUCLID;
         range_metric  = METRIC_EUCLID;
         domain_dims   = '0;
         domain_sum    = 0;
         range_sum     = 0;
         coord_pos     = '0;
         errors        = 0;
      endfunction

      function void set_config(logic [METRIC_W-1:0] dm, logic [METRIC_W-1:0] rm,
                               logic [DIMS_W-1:0] dims);
         domain_metric = dm;
         range_metric  = rm;
         domain_dims   = dims;
      endfunction

      function wide_type fold(logic [METRIC_W-1:0] metric, wide_type acc, wide_type gap);
         wide_type total;
         if (metric == METRIC_EUCLID) begin
            total = acc + gap * gap;
         end else if (metric == METRIC_MAX) begin
            total = (gap > acc) ? gap : acc;
         end else begin
            total = acc + gap;
         end
         return (total > ACC_LIMIT) ? ACC_LIMIT : total;
      endfunction

      function wide_type floor_root(wide_type v);
         wide_type root;
         wide_type trial;
         root = 0;
         for (int k = 20; k >= 0; k--) begin
            trial = root | (wide_type'(1) << k);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function wide_type part_length(logic [METRIC_W-1:0] metric, wide_type acc);
         wide_type len;
         len = (metric == METRIC_EUCLID) ? floor_root(acc) : acc;
         return (len > DIST_LIMIT) ? DIST_LIMIT : len;
      endfunction

      function void note_coord(coord_type a, coord_type b, logic last);
         int       gap;
         wide_type dd;
         wide_type rd;
         gap = int'(a) - int'(b);
         if (gap < 0) gap = -gap;
         if (coord_pos < domain_dims)
            domain_sum = fold(domain_metric, domain_sum, wide_type'(gap));
         else
            range_sum = fold(range_metric, range_sum, wide_type'(gap));
         if (coord_pos != INDEX_MAX) coord_pos++;
         if (last) begin
            dd = part_length(domain_metric, domain_sum);
            rd = part_length(range_metric, range_sum);
            expected_distances.push_back((dd > rd) ? dd[DIST_W-1:0] : rd[DIST_W-1:0]);
            domain_sum = 0;
            range_sum  = 0;
            coord_pos  = '0;
         end
      endfunction

      function int pending();
         return expected_distances.size();
      endfunction

      function void check_distance(logic [DIST_W-1:0] actual);
         logic [DIST_W-1:0] want;
         if (expected_distances.size() == 0) begin
            $error("distance: no beat expected, actual %0d", actual);
            errors++;
         end else begin
            want = expected_distances.pop_front();
            if (actual !== want) begin
               $error("distance: expected %0d, actual %0d", want, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   coord_type              req_coord_a = '0;
   coord_type              req_coord_b = '0;
   logic                   req_last_coord = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DIST_W-1:0]      rsp_distance;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   distance_scoreboard sb;
   int cycle_count = 0;
   int burst_left = 5;
   int ready_hold = 0;

   vector_distance_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coord_a    (req_coord_a),
      .req_coord_b    (req_coord_b),
      .req_last_coord (req_last_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_distance   (rsp_distance),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side stall pattern, style chosen by bits 9:8 of the cycle count
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case (cycle_count[9:8])
            2'd0: begin
               rsp_ready  <= 1'b1;
               ready_hold <= $urandom_range(0, 20);
            end
            2'd1: begin
               rsp_ready  <= 1'($urandom_range(0, 1));
               ready_hold <= 0;
            end
            2'd2: begin
               rsp_ready  <= ($urandom_range(0, 3) != 0);
               ready_hold <= $urandom_range(0, 3);
            end
            default: begin
               rsp_ready  <= 1'($urandom_range(0, 1));
               ready_hold <= $urandom_range(0, 11);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_distance(rsp_distance);
   end

   task automatic send_beat(input coord_type a, input coord_type b, input logic last);
      req_valid      <= 1'b1;
      req_coord_a    <= a;
      req_coord_b    <= b;
      req_last_coord <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_coord(a, b, last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_regs(input logic [METRIC_W-1:0] dm, input logic [METRIC_W-1:0] rm,
                             input logic [DIMS_W-1:0] dims);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DOMAIN_METRIC;
      csr_data     <= CSR_DATA_W'(dm);
      @(posedge clock);
      csr_index <= CSR_RANGE_METRIC;
      csr_data  <= CSR_DATA_W'(rm);
      @(posedge clock);
      csr_index <= CSR_DOMAIN_DIMS;
      csr_data  <= CSR_DATA_W'(dims);
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_config(dm, rm, dims);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic coord_type extreme_value();
      case ($urandom_range(0, 5))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         4:       return 16'sd1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_vector(input int len, input int fill);
      coord_type a;
      coord_type b;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_EXTREME: begin
               a = extreme_value();
               b = extreme_value();
            end
            FILL_CLOSE: begin
               a = coord_type'($urandom);
               b = a + coord_type'($urandom_range(0, 16)) - 16'sd8;
            end
            FILL_SPREAD: begin
               a = i[0] ? 16'sh8000 : 16'sh7fff;
               b = i[0] ? 16'sh7fff : 16'sh8000;
            end
            default: begin
               a = coord_type'($urandom);
               b = coord_type'($urandom);
            end
         endcase
         send_beat(a, b, i == len - 1);
      end
   endtask

   function automatic int pick_len(input int dims);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 6);
      if (r < 80) begin
         // straddle the domain/range boundary
         if (dims >= 1 && dims <= 40) return dims - 1 + $urandom_range(0, 3) + (dims == 1);
         return $urandom_range(1, 3);
      end
      return $urandom_range(7, 24);
   endfunction

   task automatic random_traffic(input int count, input int long_len, input int long_fill);
      int sent;
      int len;
      bit long_done;
      sent      = 0;
      long_done = (long_len == 0);
      while (sent < count || !long_done) begin
         if (!long_done && sent >= count / 2) begin
            send_vector(long_len, long_fill);
            long_done = 1'b1;
         end else begin
            len = pick_len(sb.domain_dims);
            send_vector(len, $urandom_range(FILL_RANDOM, FILL_CLOSE));
            sent += len;
         end
      end
   endtask

   task automatic run_phase(input logic [METRIC_W-1:0] dm, input logic [METRIC_W-1:0] rm,
                            input logic [DIMS_W-1:0] dims, input int long_len,
                            input int long_fill);
      write_regs(dm, rm, dims);
      random_traffic(22, long_len, long_fill);
      drain();
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain euclidean
      send_beat(16'sh7fff, 16'sh8000, 1'b1);
      send_beat(16'sh8000, 16'sh7fff, 1'b1);
      send_beat(16'sd0, 16'sd0, 1'b1);
      send_beat(16'sh8000, 16'sh8000, 1'b1);
      send_beat(16'sd3, 16'sd0, 1'b0);
      send_beat(-16'sd4, 16'sd0, 1'b1);
      send_beat(-16'sd1, 16'sd1, 1'b0);
      send_beat(16'sd1, -16'sd1, 1'b0);
      send_beat(16'sh7fff, 16'sh7fff, 1'b1);
      send_beat(16'sd100, -16'sd100, 1'b0);
      send_beat(-16'sd5, 16'sd6, 1'b0);
      send_beat(16'sd0, -16'sd1, 1'b1);
      drain();

      write_regs(METRIC_MAX, METRIC_TAXICAB, 9'd2);
      send_beat(16'sd10, -16'sd10, 1'b0);
      send_beat(-16'sd3, 16'sd3, 1'b0);
      send_beat(16'sd5, 16'sd0, 1'b0);
      send_beat(16'sd0, 16'sd7, 1'b1);
      send_beat(16'sh7fff, 16'sh8000, 1'b0);
      send_beat(16'sd0, 16'sd0, 1'b1);
      drain();

      write_regs(METRIC_SPARE, METRIC_MAX, 9'd1);
      send_beat(16'sd1, 16'sd2, 1'b0);
      send_beat(16'sd3, 16'sd5, 1'b1);
      send_beat(16'sh8000, 16'sd0, 1'b1);
      drain();

      run_phase(METRIC_EUCLID, METRIC_EUCLID, 9'd0, 260, FILL_SPREAD);
      run_phase(METRIC_TAXICAB, METRIC_TAXICAB, 9'd0, 260, FILL_SPREAD);
      run_phase(METRIC_MAX, METRIC_MAX, 9'd0, 0, FILL_RANDOM);
      run_phase(METRIC_SPARE, METRIC_SPARE, 9'd0, 0, FILL_RANDOM);
      run_phase(METRIC_EUCLID, METRIC_TAXICAB, 9'd3, 0, FILL_RANDOM);
      run_phase(METRIC_TAXICAB, METRIC_EUCLID, 9'd1, 0, FILL_RANDOM);
      run_phase(METRIC_MAX, METRIC_EUCLID, 9'd256, 258, FILL_EXTREME);
      // vector longer than the index range with every coordinate but the tail in domain
      run_phase(METRIC_EUCLID, METRIC_MAX, 9'd511, 515, FILL_RANDOM);
      run_phase(METRIC_TAXICAB, METRIC_MAX, 9'd2, 0, FILL_RANDOM);
      run_phase(METRIC_MAX, METRIC_TAXICAB, 9'd5, 0, FILL_RANDOM);
      run_phase(METRIC_SPARE, METRIC_EUCLID, 9'd4, 0, FILL_RANDOM);
      run_phase(METRIC_EUCLID, METRIC_SPARE, 9'd7, 0, FILL_RANDOM);
      run_phase(METRIC_W'($urandom_range(0, 3)), METRIC_W'($urandom_range(0, 3)),
                DIMS_W'($urandom_range(0, 12)), 0, FILL_RANDOM);
      run_phase(METRIC_EUCLID, METRIC_EUCLID, 9'd0, 0, FILL_RANDOM);

      sb.errors += sb.pending();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
rtl/vde_pkg.sv
rtl/vde_front.sv
rtl/vde_queue.sv
rtl/vde_back.sv
rtl/vector_distance_engine.sv
sim/vector_distance_engine_test.sv
